// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the IPv4 header checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IHC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ipv4_header_checker: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IHC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ipv4_header_checker: next-cycle check failed");

`endif

// ===== rtl/ihc_pkg.sv =====
// Constants, types and the checksum function used by the IPv4 header checker.
package ihc_pkg;

   localparam int unsigned HdrBytes = 20;
   localparam int unsigned PosWidth = 5;

   localparam logic [PosWidth-1:0] LAST_POS       = PosWidth'(HdrBytes - 1);
   localparam logic [7:0]          VERSION_IHL    = 8'h45;
   localparam logic [31:0]         BCAST_ADDR     = 32'hFFFF_FFFF;
   localparam logic [15:0]         SUM_GOOD       = 16'hFFFF;
   localparam logic [15:0]         HDR_LEN        = 16'(HdrBytes);

   // Header byte positions of the captured fields.
   localparam logic [PosWidth-1:0] POS_VERSION    = 5'd0;
   localparam logic [PosWidth-1:0] POS_LEN_HI     = 5'd2;
   localparam logic [PosWidth-1:0] POS_LEN_LO     = 5'd3;
   localparam logic [PosWidth-1:0] POS_PROTOCOL   = 5'd9;
   localparam logic [PosWidth-1:0] POS_SRC_FIRST  = 5'd12;
   localparam logic [PosWidth-1:0] POS_SRC_LAST   = 5'd15;
   localparam logic [PosWidth-1:0] POS_DST_FIRST  = 5'd16;

   typedef logic [PosWidth-1:0] pos_type;

   // One verdict as it leaves the block.
   typedef struct packed {
      logic        accepted;
      logic [7:0]  protocol;
      logic [31:0] source_ip;
      logic [15:0] payload_length;
      logic        to_broadcast;
   } verdict_type;

   // Ones'-complement add with end-around carry. The second add cannot carry
   // again, because the low half is at most 0xFFFE when a carry came out.
   function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
      logic [16:0] raw;
      raw = {1'b0, acc} + {1'b0, word};
      return raw[15:0] + {15'd0, raw[16]};
   endfunction

endpackage

// ===== rtl/ipv4_header_checker.sv =====
// IPv4 header checker: per-byte header parsing, checksum and verdict.
//
// The block takes a 20-byte IPv4 header one byte per item on the req_
// channel; req_first_byte marks byte 0 and always restarts parsing, dropping
// any unfinished header. Bytes with req_first_byte low while no header is
// open are discarded. After byte 19 one verdict leaves on the rsp_ channel:
// accepted only for version/IHL 0x45, a ones'-complement sum of 0xFFFF, a
// destination equal to csr_wr_data as last written or the broadcast address,
// and a total length above 20. Protocol, source address and the broadcast
// mark are reported either way; the payload length is zero when rejected.
// Each byte passes through an input register, then one stage of logic that
// updates the running sum and captured fields into the result register, so
// a verdict is offered after its last byte has passed the update stage.
// One byte is taken per cycle while the result register can move, that is
// while it is empty or rsp_ready is high. When the receiver stalls with a
// verdict waiting, the input register still takes one more byte, then
// req_ready drops until rsp_ready returns. Reset empties both registers,
// closes any open header and clears the local address to zero.
module ipv4_header_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_header_byte,
   input  logic        req_first_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic [7:0]  rsp_protocol,
   output logic [31:0] rsp_source_ip,
   output logic [15:0] rsp_payload_length,
   output logic        rsp_to_broadcast,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import ihc_pkg::*;

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_first_ff;

   // Header state.
   pos_type     pos_ff, pos_in;
   logic [15:0] sum_ff, sum_in;
   logic        version_ok_ff, version_ok_in;
   logic [15:0] total_len_ff, total_len_in;
   logic [7:0]  protocol_ff, protocol_in;
   logic [31:0] source_ff, source_in;
   logic [31:0] dest_ff, dest_in;
   logic [31:0] local_ip_ff;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type verdict_ff, verdict_in;

   logic        out_free;
   logic        proc_fire;
   logic        active;
   pos_type     pos_cur;
   logic        last_byte;
   logic [15:0] word;
   logic        bcast;
   logic        addr_ok;
   logic        ok;

   // The result register is free when empty or being emptied this cycle;
   // the stored byte moves on only then, so no verdict is ever overwritten.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign proc_fire = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_comb begin
      pos_cur   = in_first_ff ? POS_VERSION : pos_ff;
      active    = in_first_ff || (pos_ff != POS_VERSION && pos_ff <= LAST_POS);
      last_byte = active && (pos_cur == LAST_POS);
      // Even positions are high halves of a 16-bit word, odd ones low halves.
      word      = pos_cur[0] ? {8'd0, in_byte_ff} : {in_byte_ff, 8'd0};

      pos_in        = pos_ff;
      sum_in        = sum_ff;
      version_ok_in = version_ok_ff;
      total_len_in  = total_len_ff;
      protocol_in   = protocol_ff;
      source_in     = source_ff;
      dest_in       = dest_ff;

      if (proc_fire && active) begin
         sum_in = ones_add(in_first_ff ? 16'd0 : sum_ff, word);
         pos_in = last_byte ? POS_VERSION : pos_cur + 5'd1;
         if (pos_cur == POS_VERSION) begin
            version_ok_in = (in_byte_ff == VERSION_IHL);
         end else if (pos_cur == POS_LEN_HI || pos_cur == POS_LEN_LO) begin
            total_len_in = {total_len_ff[7:0], in_byte_ff};
         end else if (pos_cur == POS_PROTOCOL) begin
            protocol_in = in_byte_ff;
         end else if (pos_cur >= POS_SRC_FIRST && pos_cur <= POS_SRC_LAST) begin
            source_in = {source_ff[23:0], in_byte_ff};
         end else if (pos_cur >= POS_DST_FIRST) begin
            dest_in = {dest_ff[23:0], in_byte_ff};
         end
      end

      // Verdict from the state as it stands after the final byte.
      bcast   = (dest_in == BCAST_ADDR);
      addr_ok = bcast || (dest_in == local_ip_ff);
      ok      = version_ok_in && (sum_in == SUM_GOOD) && addr_ok && (total_len_in > HDR_LEN);

      verdict_in.accepted       = ok;
      verdict_in.protocol       = protocol_in;
      verdict_in.source_ip      = source_in;
      verdict_in.payload_length = ok ? total_len_in - HDR_LEN : 16'd0;
      verdict_in.to_broadcast   = bcast;

      in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !out_free);
      rsp_valid_in = (proc_fire && last_byte) || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pos_ff        <= POS_VERSION;
         sum_ff        <= 16'd0;
         version_ok_ff <= 1'b0;
         total_len_ff  <= 16'd0;
         protocol_ff   <= 8'd0;
         source_ff     <= 32'd0;
         dest_ff       <= 32'd0;
         local_ip_ff   <= 32'd0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pos_ff        <= pos_in;
         sum_ff        <= sum_in;
         version_ok_ff <= version_ok_in;
         total_len_ff  <= total_len_in;
         protocol_ff   <= protocol_in;
         source_ff     <= source_in;
         dest_ff       <= dest_in;
         if (csr_wr_en) begin
            local_ip_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers: loaded on acceptance and on a final byte only.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_header_byte;
         in_first_ff <= req_first_byte;
      end
      if (proc_fire && last_byte) begin
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = verdict_ff.accepted;
   assign rsp_protocol       = verdict_ff.protocol;
   assign rsp_source_ip      = verdict_ff.source_ip;
   assign rsp_payload_length = verdict_ff.payload_length;
   assign rsp_to_broadcast   = verdict_ff.to_broadcast;

`include "assert_macros.svh"

   `IHC_ASSERT_NEXT(a_final_byte_gives_verdict, proc_fire && last_byte, rsp_valid)
   `IHC_ASSERT_IMP(a_position_in_range, 1'b1, pos_ff <= LAST_POS)
   `IHC_ASSERT_IMP(a_rejected_has_no_length, rsp_valid && !rsp_accepted, rsp_payload_length == 16'd0)
   `IHC_ASSERT_NEXT(a_stall_blocks_input, rsp_valid && !rsp_ready && in_valid_ff, !req_ready || rsp_valid)

endmodule
